// File: sv/object_position_dedup_table_macros.svh
// Assertion macros shared by the de-duplication table RTL.
// OPDT_ASSERT_NOW checks the consequent in the same cycle as the antecedent.
// OPDT_ASSERT_NEXT checks it in the following cycle.
`ifndef OBJECT_POSITION_DEDUP_TABLE_MACROS_SVH
`define OBJECT_POSITION_DEDUP_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define OPDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define OPDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OPDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define OPDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/opdt_pkg.sv
`default_nettype none

package opdt_pkg;

    localparam int CLASS_W    = 5;
    localparam int POS_W      = 20;
    localparam int MARGIN_W   = 16;
    localparam int MASK_W     = 32;
    localparam int SQ_W       = 2 * POS_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int M2_W       = 2 * MARGIN_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_ENABLE_MASK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_MM         = CFG_IDX_W'(1);

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1000);

    typedef struct packed {
        logic [CLASS_W-1:0]      obj_class;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_in;

    typedef struct packed {
        logic tracked;
        logic is_new;
        logic stored;
        logic table_full;
    } t_out;

    // One stored table entry, as held by a cell of the ring.
    typedef struct packed {
        logic [CLASS_W-1:0]      obj_class;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_entry;

    // Control from the sequencer into the distance unit.
    typedef struct packed {
        logic                    clear;
        logic                    valid;
        logic signed [POS_W-1:0] ent_x;
        logic signed [POS_W-1:0] ent_y;
    } t_probe;

    // Status from the distance unit back to the sequencer.
    typedef struct packed {
        logic pending;
        logic match;
    } t_dist_status;

endpackage

`default_nettype wire

// File: sv/object_position_dedup_table.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------
// item in   | start, busy                | i_item (obj_class, pos_x, pos_y)
// result    | o_result_valid (one cycle) | o_result (tracked, is_new, stored,
//           |                            |           table_full)
// config    | i_cfg_we, i_cfg_idx        | i_cfg_data
//
// An item of a disabled class gives its result in the cycle after the transfer and busy
// stays low, so the next item may follow at once.
// A tracked item rotates the ring of TABLE_DEPTH cells once past the distance unit, one
// entry per cycle, then waits for that unit's pipeline to empty: busy stays high throughout
// and the result is shown in the first cycle with busy low again.
// Reset is synchronous and empties the table at once; no clearing pass is needed.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none

`include "object_position_dedup_table_macros.svh"

module object_position_dedup_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int CLASS_COUNT = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire opdt_pkg::t_in                       i_item,
    output logic                                     busy,
    output logic                                     o_result_valid,
    output opdt_pkg::t_out                           o_result,
    input  wire logic                                i_cfg_we,
    input  wire logic [opdt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [opdt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int STEP_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                      r_state;
    logic [opdt_pkg::MASK_W-1:0]     r_mask;
    logic [opdt_pkg::MARGIN_W-1:0]   r_margin;
    logic [FILL_W-1:0]               r_fill;
    logic [STEP_W-1:0]               r_step;
    logic                            r_result_valid;
    opdt_pkg::t_out                  r_result;
    opdt_pkg::t_in                   r_query;
    logic [opdt_pkg::M2_W-1:0]       r_m2;

    opdt_pkg::t_entry                w_cells [TABLE_DEPTH];
    opdt_pkg::t_entry                w_load_data;
    opdt_pkg::t_probe                w_probe;
    opdt_pkg::t_dist_status          w_status;
    logic                            w_accept;
    logic                            w_tracked;
    logic                            w_shift;
    logic                            w_full;
    logic                            w_finish;
    logic                            w_store;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // The mask has one bit per possible class code; classes past CLASS_COUNT stay off.
    assign w_tracked = (int'(i_item.obj_class) < CLASS_COUNT) && r_mask[i_item.obj_class];

    assign w_shift  = (r_state == ST_SCAN);
    assign w_full   = (r_fill == FILL_W'(TABLE_DEPTH));
    assign w_finish = (r_state == ST_DRAIN) && !w_status.pending;
    assign w_store  = w_finish && !w_status.match && !w_full;

    assign w_load_data.obj_class = r_query.obj_class;
    assign w_load_data.pos_x     = r_query.pos_x;
    assign w_load_data.pos_y     = r_query.pos_y;

    // Cell 0 is the head of the ring: after r_step shifts it holds entry r_step, and
    // entries at or above the fill count hold no valid data.
    assign w_probe.clear = w_accept;
    assign w_probe.valid = w_shift && (FILL_W'(r_step) < r_fill)
                         && (w_cells[0].obj_class == r_query.obj_class);
    assign w_probe.ent_x = w_cells[0].pos_x;
    assign w_probe.ent_y = w_cells[0].pos_y;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_ring
        opdt_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_load      (w_store && (r_fill == FILL_W'(g))),
            .i_next      (w_cells[(g + 1) % TABLE_DEPTH]),
            .i_load_data (w_load_data),
            .o_entry     (w_cells[g])
        );
    end

    opdt_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_probe  (w_probe),
        .i_qx     (r_query.pos_x),
        .i_qy     (r_query.pos_y),
        .i_m2     (r_m2),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mask         <= '0;
            r_margin       <= opdt_pkg::MARGIN_RESET;
            r_fill         <= '0;
            r_step         <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    opdt_pkg::REG_CLASS_ENABLE_MASK: begin
                        r_mask <= i_cfg_data[opdt_pkg::MASK_W-1:0];
                    end
                    opdt_pkg::REG_MARGIN_MM: begin
                        r_margin <= i_cfg_data[opdt_pkg::MARGIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_step <= '0;
                        if (w_tracked) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_result_valid <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    r_step <= STEP_W'(r_step + 1'b1);
                    if (r_step == STEP_W'(TABLE_DEPTH - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_finish) begin
                        r_result_valid <= 1'b1;
                        r_state        <= ST_IDLE;
                        if (w_store) begin
                            r_fill <= FILL_W'(r_fill + 1'b1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query <= i_item;
            r_m2    <= opdt_pkg::M2_W'(r_margin) * opdt_pkg::M2_W'(r_margin);
            if (!w_tracked) begin
                r_result <= '0;
            end
        end
        if (w_finish) begin
            r_result.tracked    <= 1'b1;
            r_result.is_new     <= !w_status.match;
            r_result.stored     <= w_store;
            r_result.table_full <= !w_status.match && w_full;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    `OPDT_ASSERT_NOW(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy, "result shown while busy")
    `OPDT_ASSERT_NOW(a_store_consistent, i_clk, i_rst_n, o_result_valid && o_result.stored, o_result.tracked && o_result.is_new && !o_result.table_full, "stored result with inconsistent flags")
    `OPDT_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(TABLE_DEPTH), "fill count beyond table depth")
    `OPDT_ASSERT_NEXT(a_untracked_fast, i_clk, i_rst_n, w_accept && !w_tracked, o_result_valid && !o_result.tracked && !busy, "disabled class not answered at once")

endmodule

`default_nettype wire

// File: sv/opdt_cell.sv
`default_nettype none

module opdt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_shift,
    input  wire logic            i_load,
    input  wire opdt_pkg::t_entry i_next,
    input  wire opdt_pkg::t_entry i_load_data,
    output opdt_pkg::t_entry     o_entry
);

    opdt_pkg::t_entry r_entry;

    // Loading only happens with the ring at rest, so the two never coincide.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: sv/opdt_dist.sv
`default_nettype none

module opdt_dist (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire opdt_pkg::t_probe                   i_probe,
    input  wire logic signed [opdt_pkg::POS_W-1:0]  i_qx,
    input  wire logic signed [opdt_pkg::POS_W-1:0]  i_qy,
    input  wire logic [opdt_pkg::M2_W-1:0]          i_m2,
    output opdt_pkg::t_dist_status                  o_status
);

    logic [opdt_pkg::POS_W:0]   w_dx_diff;
    logic [opdt_pkg::POS_W:0]   w_dy_diff;
    logic [opdt_pkg::POS_W:0]   w_dx_mag;
    logic [opdt_pkg::POS_W:0]   w_dy_mag;
    logic [opdt_pkg::SQ_W-1:0]  w_dx2;
    logic [opdt_pkg::SQ_W-1:0]  w_dy2;
    logic [opdt_pkg::SUM_W-1:0] w_sum;
    logic                       w_hit;

    logic                       r_s1_v;
    logic [opdt_pkg::POS_W-1:0] r_dx;
    logic [opdt_pkg::POS_W-1:0] r_dy;
    logic                       r_s2_v;
    logic [opdt_pkg::SQ_W-1:0]  r_dx2;
    logic [opdt_pkg::SQ_W-1:0]  r_dy2;
    logic                       r_match;

    // Differences are taken one bit wider; the magnitude always fits POS_W bits.
    assign w_dx_diff = {i_qx[opdt_pkg::POS_W-1], i_qx}
                     - {i_probe.ent_x[opdt_pkg::POS_W-1], i_probe.ent_x};
    assign w_dy_diff = {i_qy[opdt_pkg::POS_W-1], i_qy}
                     - {i_probe.ent_y[opdt_pkg::POS_W-1], i_probe.ent_y};
    assign w_dx_mag  = w_dx_diff[opdt_pkg::POS_W] ? (~w_dx_diff + 1'b1) : w_dx_diff;
    assign w_dy_mag  = w_dy_diff[opdt_pkg::POS_W] ? (~w_dy_diff + 1'b1) : w_dy_diff;

    assign w_dx2 = opdt_pkg::SQ_W'(r_dx) * opdt_pkg::SQ_W'(r_dx);
    assign w_dy2 = opdt_pkg::SQ_W'(r_dy) * opdt_pkg::SQ_W'(r_dy);

    assign w_sum = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_hit = r_s2_v && (w_sum <= opdt_pkg::SUM_W'(i_m2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_s1_v <= i_probe.valid;
            r_s2_v <= r_s1_v;
            if (i_probe.clear) begin
                r_match <= 1'b0;
            end else if (w_hit) begin
                r_match <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= w_dx_mag[opdt_pkg::POS_W-1:0];
        r_dy  <= w_dy_mag[opdt_pkg::POS_W-1:0];
        r_dx2 <= w_dx2;
        r_dy2 <= w_dy2;
    end

    assign o_status.pending = r_s1_v | r_s2_v;
    assign o_status.match   = r_match;

endmodule

`default_nettype wire

// File: sim/object_position_dedup_table_test.sv
`timescale 1ns / 100ps

module object_position_dedup_table_test;

    localparam int TABLE_DEPTH = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 80;
    localparam int PRINT_LIMIT = 50;
    localparam int CLASS_W     = opdt_pkg::CLASS_W;
    localparam int POS_W       = opdt_pkg::POS_W;
    localparam int MASK_W      = opdt_pkg::MASK_W;
    localparam int MARGIN_W    = opdt_pkg::MARGIN_W;
    localparam int CFG_IDX_W   = opdt_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = opdt_pkg::CFG_DATA_W;
    // Indexes past the end of the register list; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    opdt_pkg::t_in         i_item     = '0;
    logic                  busy;
    logic                  o_result_valid;
    opdt_pkg::t_out        o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the block's registers and table.
    logic [MASK_W-1:0]       enable_mask = '0;
    logic [MARGIN_W-1:0]     margin      = opdt_pkg::MARGIN_RESET;
    logic [CLASS_W-1:0]      entry_cls [TABLE_DEPTH];
    logic signed [POS_W-1:0] entry_px  [TABLE_DEPTH];
    logic signed [POS_W-1:0] entry_py  [TABLE_DEPTH];
    int                      fill_level = 0;

    opdt_pkg::t_out expected_results [$];

    int objects_sent   = 0;
    int untracked_sent = 0;
    int stored_sent    = 0;
    int seen_sent      = 0;
    int dropped_sent   = 0;
    int results_seen   = 0;
    int config_writes  = 0;
    int mismatches     = 0;
    int stall_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    object_position_dedup_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CLASS_COUNT (32)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // Works out the verdict for one object and updates the shadow table as the block would.
    function automatic opdt_pkg::t_out classify_object(input opdt_pkg::t_in obj);
        opdt_pkg::t_out res;
        longint         reach2;
        longint         dx;
        longint         dy;
        res = '0;
        reach2 = longint'(margin) * longint'(margin);
        if (enable_mask[obj.obj_class]) begin
            res.tracked = 1'b1;
            res.is_new = 1'b1;
            for (int i = 0; i < fill_level; i++) begin
                if (entry_cls[i] == obj.obj_class) begin
                    dx = longint'($signed(obj.pos_x)) - longint'($signed(entry_px[i]));
                    dy = longint'($signed(obj.pos_y)) - longint'($signed(entry_py[i]));
                    if (dx * dx + dy * dy <= reach2) begin
                        res.is_new = 1'b0;
                        break;
                    end
                end
            end
            if (res.is_new) begin
                if (fill_level < TABLE_DEPTH) begin
                    entry_cls[fill_level] = obj.obj_class;
                    entry_px[fill_level] = obj.pos_x;
                    entry_py[fill_level] = obj.pos_y;
                    fill_level++;
                    res.stored = 1'b1;
                end else begin
                    res.table_full = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Holds start high until the block takes the object; start is left high on return.
    task automatic send_object(input opdt_pkg::t_in obj);
        opdt_pkg::t_out res;
        i_item <= obj;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        res = classify_object(obj);
        expected_results = {expected_results, res};
        objects_sent++;
        if (!res.tracked) begin
            untracked_sent++;
        end else if (res.stored) begin
            stored_sent++;
        end else if (res.table_full) begin
            dropped_sent++;
        end else begin
            seen_sent++;
        end
    endtask

    task automatic send_at(input int cls, input int px, input int py);
        opdt_pkg::t_in obj;
        obj.obj_class = CLASS_W'(cls);
        obj.pos_x = POS_W'(px);
        obj.pos_y = POS_W'(py);
        send_object(obj);
    endtask

    // Either idles straight away or first lets the current search finish.
    task automatic idle_sender();
        start <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            do @(posedge i_clk); while (busy !== 1'b0);
        end
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            opdt_pkg::REG_CLASS_ENABLE_MASK: enable_mask = value[MASK_W-1:0];
            opdt_pkg::REG_MARGIN_MM:         margin = value[MARGIN_W-1:0];
            default: ;
        endcase
        config_writes++;
        @(posedge i_clk);
    endtask

    // Mostly objects placed around an entry already held, inside, on or just past the
    // margin, so that the table fills slowly; the rest land anywhere.
    function automatic opdt_pkg::t_in make_object();
        opdt_pkg::t_in obj;
        int            near_idx [$];
        int            pick;
        int            mode;
        int            span;
        int            dx;
        int            dy;
        longint        rem;
        obj.obj_class = CLASS_W'($urandom_range(0, 31));
        if (enable_mask != '0 && $urandom_range(0, 99) < 85) begin
            while (!enable_mask[obj.obj_class]) begin
                obj.obj_class = CLASS_W'($urandom_range(0, 31));
            end
        end
        for (int i = 0; i < fill_level; i++) begin
            if (entry_cls[i] == obj.obj_class) begin
                near_idx = {near_idx, i};
            end
        end
        if (near_idx.size() == 0 || $urandom_range(0, 99) < 10) begin
            obj.pos_x = POS_W'($urandom);
            obj.pos_y = POS_W'($urandom);
        end else begin
            pick = near_idx[$urandom_range(0, near_idx.size() - 1)];
            mode = $urandom_range(0, 99);
            if (mode < 55) begin
                span = int'(margin) * 7 / 10;
                dx = int'($urandom_range(0, 2 * span)) - span;
                dy = int'($urandom_range(0, 2 * span)) - span;
            end else if (mode < 75) begin
                // On the circle of the margin, or one step outside it.
                dx = $urandom_range(0, margin);
                rem = longint'(margin) * longint'(margin) - longint'(dx) * longint'(dx);
                dy = int'($floor($sqrt(real'(rem))));
                if ($urandom_range(0, 1) == 1) begin
                    dy++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    dx = -dx;
                end
                if ($urandom_range(0, 1) == 1) begin
                    dy = -dy;
                end
            end else begin
                span = int'(margin) + int'(margin) / 8 + 1;
                dx = int'($urandom_range(0, 2 * span)) - span;
                dy = int'($urandom_range(0, 2 * span)) - span;
            end
            obj.pos_x = POS_W'(int'($signed(entry_px[pick])) + dx);
            obj.pos_y = POS_W'(int'($signed(entry_py[pick])) + dy);
        end
        return obj;
    endfunction

    // Runs until the given number of tracked objects has been sent.
    task automatic run_objects(input int count, input int gap_pct);
        int goal;
        int roll;
        goal = objects_sent - untracked_sent + count;
        while (objects_sent - untracked_sent < goal) begin
            send_object(make_object());
            roll = $urandom_range(0, 99);
            if (gap_pct > 0 && roll < 3) begin
                drain_results();
            end else if (gap_pct > 0 && roll < 3 + gap_pct) begin
                idle_sender();
            end
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_mask();
        return CFG_DATA_W'($urandom) | (CFG_DATA_W'(1) << $urandom_range(0, 31));
    endfunction

    task automatic test_reset_defaults();
        // Nothing is enabled out of reset, and the margin starts at 1000 mm.
        send_at(0, 0, 0);
        send_at(31, -524288, 524287);
        drain_results();
        write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, CFG_DATA_W'(1) << 3);
        send_at(3, 100, 100);
        send_at(3, 1100, 100);
        send_at(3, 1101, 100);
        send_at(4, 100, 100);
    endtask

    task automatic test_bad_index();
        drain_results();
        write_register(REG_SPARE, '0);
        write_register(REG_TOP, '0);
        send_at(3, 100, 100);
        drain_results();
        write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, '0);
        send_at(3, 100, 100);
    endtask

    task automatic test_margin_zero();
        drain_results();
        write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, '1);
        write_register(opdt_pkg::REG_MARGIN_MM, '0);
        send_at(7, -5, -5);
        send_at(7, -5, -5);
        send_at(7, -4, -5);
        send_at(8, -5, -5);
    endtask

    task automatic test_margin_edge();
        // A 3-4-5 triangle sits exactly on the margin and so counts as seen.
        drain_results();
        write_register(opdt_pkg::REG_MARGIN_MM, CFG_DATA_W'(5));
        send_at(9, 0, 0);
        send_at(9, 3, 4);
        send_at(9, -3, -5);
    endtask

    task automatic test_extremes();
        drain_results();
        write_register(opdt_pkg::REG_MARGIN_MM, CFG_DATA_W'(65535));
        send_at(31, -524288, -524288);
        send_at(31, 524287, 524287);
        send_at(0, -524288, 524287);
        send_at(0, -524288 + 65535, 524287);
        send_at(31, 524287 - 40000, 524287 - 50000);
    endtask

    task automatic test_random_traffic();
        int gap_pct;
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, '1);
                    write_register(opdt_pkg::REG_MARGIN_MM,
                                   CFG_DATA_W'($urandom_range(1, 2000)));
                    gap_pct = 35;
                end
                1: begin
                    write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, random_mask());
                    write_register(opdt_pkg::REG_MARGIN_MM, '0);
                    gap_pct = 20;
                end
                2: begin
                    write_register(opdt_pkg::REG_CLASS_ENABLE_MASK,
                                   ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h1);
                    write_register(opdt_pkg::REG_MARGIN_MM, CFG_DATA_W'(65535));
                    gap_pct = 50;
                end
                3: begin
                    write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, random_mask());
                    write_register(opdt_pkg::REG_MARGIN_MM,
                                   CFG_DATA_W'($urandom_range(0, 65535)));
                    gap_pct = 0;
                end
                4: begin
                    write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, '1);
                    write_register(opdt_pkg::REG_MARGIN_MM, CFG_DATA_W'(1));
                    gap_pct = 25;
                end
                default: begin
                    write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, random_mask());
                    write_register(opdt_pkg::REG_MARGIN_MM,
                                   CFG_DATA_W'($urandom_range(1, 300)));
                    gap_pct = 10;
                end
            endcase
            run_objects(105, gap_pct);
        end
    endtask

    task automatic test_table_full();
        opdt_pkg::t_in obj;
        drain_results();
        write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, '1);
        write_register(opdt_pkg::REG_MARGIN_MM, '0);
        while (fill_level < TABLE_DEPTH) begin
            obj.obj_class = CLASS_W'($urandom_range(0, 31));
            obj.pos_x = POS_W'($urandom);
            obj.pos_y = POS_W'($urandom);
            send_object(obj);
        end
        repeat (6) begin
            obj.obj_class = CLASS_W'($urandom_range(0, 31));
            obj.pos_x = POS_W'($urandom);
            obj.pos_y = POS_W'($urandom);
            send_object(obj);
        end
        // Matching must still work once nothing more can be stored.
        obj.obj_class = entry_cls[0];
        obj.pos_x = entry_px[0];
        obj.pos_y = entry_py[0];
        send_object(obj);
    endtask

    task automatic test_back_to_back();
        drain_results();
        write_register(opdt_pkg::REG_CLASS_ENABLE_MASK, '1);
        write_register(opdt_pkg::REG_MARGIN_MM, CFG_DATA_W'($urandom_range(100, 5000)));
        run_objects(120, 0);
    endtask

    // Each result is shown for one cycle only, so it is checked at the edge that ends it.
    always @(posedge i_clk) begin
        opdt_pkg::t_out want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %b with no object outstanding", o_result));
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                if (o_result.tracked !== want.tracked || o_result.is_new !== want.is_new ||
                    o_result.stored !== want.stored ||
                    o_result.table_full !== want.table_full) begin
                    report_mismatch($sformatf(
                        "result %0d: tracked %b/%b is_new %b/%b stored %b/%b full %b/%b",
                        results_seen, o_result.tracked, want.tracked, o_result.is_new,
                        want.is_new, o_result.stored, want.stored, o_result.table_full,
                        want.table_full));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_bad_index();
        test_margin_zero();
        test_margin_edge();
        test_extremes();
        test_random_traffic();
        test_table_full();
        test_back_to_back();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d objects sent, %0d of disabled classes: %0d stored, %0d matched, %0d dropped",
                 objects_sent, untracked_sent, stored_sent, seen_sent, dropped_sent);
        $display("%0d register writes, margins from 0 to 65535, %0d results checked",
                 config_writes, results_seen);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
